### design/radar_tap_swipe_gesture_detector_defines.svh
// Assertion macros for the checker file of this block.
`ifndef RADAR_TAP_SWIPE_GESTURE_DETECTOR_DEFINES_SVH
`define RADAR_TAP_SWIPE_GESTURE_DETECTOR_DEFINES_SVH

`define RTSGD_ASSERT_IMP(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
   else $error("rtsgd assertion failed");

`define RTSGD_ASSERT_NXT(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
   else $error("rtsgd assertion failed");

`endif

### design/rtsgd_pkg.sv
package rtsgd_pkg;

   localparam int ENERGY_BITS_DEF = 12;
   localparam int RSP_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEAT,
      ST_SCORE,
      ST_RANK,
      ST_SCALE,
      ST_QUOT,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic feat;
      logic score;
      logic rank;
      logic scale;
      logic quot;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } dp_status_type;

   typedef enum logic [2:0] {
      CSR_MOTION_ON,
      CSR_SWIPE_VOTES,
      CSR_GROUP_FRAMES,
      CSR_DOPPLER,
      CSR_ZONE,
      CSR_TAP_DELTA,
      CSR_TAP_RISE,
      CSR_TAP_FALL
   } csr_index_type;

   localparam logic [1:0] CLASS_BACKGROUND = 2'd0;
   localparam logic [1:0] CLASS_TAP        = 2'd1;
   localparam logic [1:0] CLASS_UP         = 2'd2;
   localparam logic [1:0] CLASS_DOWN       = 2'd3;

   localparam logic [2:0] HINT_UP   = 3'd6;
   localparam logic [2:0] HINT_DOWN = 3'd7;

   localparam logic [1:0] SWIPE_NONE       = 2'd0;
   localparam logic [1:0] SWIPE_UP_SHOWN   = 2'd1;
   localparam logic [1:0] SWIPE_DOWN_SHOWN = 2'd2;

   localparam logic [4:0] MOTION_RELEASE    = 5'd16;
   localparam logic [1:0] DEBOUNCE_FRAMES   = 2'd3;
   localparam logic [2:0] CONFIRM_TIMEOUT   = 3'd6;
   localparam logic [5:0] SUPPRESS_FRAMES   = 6'd32;
   localparam logic [4:0] GUARD_FRAMES      = 5'd24;
   localparam logic [6:0] LOCKOUT_FRAMES    = 7'd64;
   localparam logic [4:0] TRANSITION_FRAMES = 5'd20;

   localparam int DERIV_MIN    = 14;
   localparam int DERIV_MARGIN = 10;
   localparam int FAST_MARGIN  = 10;

   localparam logic [11:0] RST_MOTION_ON = 12'd20;
   localparam logic [7:0]  RST_VOTES     = 8'd2;
   localparam logic [5:0]  RST_GROUP     = 6'd22;
   localparam logic [11:0] RST_DOPPLER   = 12'd18;
   localparam logic [11:0] RST_ZONE      = 12'd20;
   localparam logic [11:0] RST_TAP_DELTA = 12'd28;
   localparam logic [11:0] RST_TAP_RISE  = 12'd42;
   localparam logic [11:0] RST_TAP_FALL  = 12'd34;

   localparam int CONF_TAP_MIN   = 1820445;
   localparam int CONF_SWIPE_MIN = 1310720;
   localparam int CONF_GUARD_MIN = 1019449;
   localparam int CONF_CLAMP_MIN = 7281778;
   localparam int RECIP_125      = 33554;

endpackage

### design/rtsgd_ctrl.sv
module rtsgd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output rtsgd_pkg::dp_cmd_type  cmd,
   input  rtsgd_pkg::dp_status_type status
);

   rtsgd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtsgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rtsgd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = rtsgd_pkg::ST_FEAT;
            end
         end
         rtsgd_pkg::ST_FEAT: begin
            cmd.feat = 1'b1;
            state_in = rtsgd_pkg::ST_SCORE;
         end
         rtsgd_pkg::ST_SCORE: begin
            cmd.score = 1'b1;
            state_in  = rtsgd_pkg::ST_RANK;
         end
         rtsgd_pkg::ST_RANK: begin
            cmd.rank = 1'b1;
            state_in = rtsgd_pkg::ST_SCALE;
         end
         rtsgd_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = rtsgd_pkg::ST_QUOT;
         end
         rtsgd_pkg::ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = rtsgd_pkg::ST_COMMIT;
         end
         rtsgd_pkg::ST_COMMIT: begin
            if (!status.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = rtsgd_pkg::ST_IDLE;
            end
         end
         default: state_in = rtsgd_pkg::ST_IDLE;
      endcase
   end

endmodule

### design/rtsgd_dp.sv
module rtsgd_dp #(
   parameter int ENERGY_BITS = rtsgd_pkg::ENERGY_BITS_DEF,
   localparam int REQ_BITS = ((ENERGY_BITS + 19 + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rtsgd_pkg::dp_cmd_type                  cmd,
   output rtsgd_pkg::dp_status_type               status,
   input  logic [REQ_BITS-1:0]                    req_tdata,
   input  logic                                   csr_valid,
   input  logic [rtsgd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rtsgd_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rtsgd_pkg::RSP_BITS-1:0]         rsp_tdata
);

   localparam int E  = ENERGY_BITS;
   localparam int SW = E + 26;
   localparam int CW = ((E > 12) ? E : 12) + 2;

   // Configuration registers.
   logic [11:0] mot_thr_ff, dop_ff, zone_ff, tds_ff, trs_ff, tfs_ff;
   logic [7:0]  votes_cfg_ff;
   logic [5:0]  group_cfg_ff;

   // Captured request.
   logic [E-1:0] e_ff;
   logic [2:0]   cls_ff;
   logic [15:0]  score_ff;

   // Tracking state.
   logic [E-1:0]        base_ff, prev_ff, noise_ff, avga_ff;
   logic signed [E:0]   avgd_ff, avgc_ff;

   // Per-frame features.
   logic signed [E:0]   delta_ff, de_ff;
   logic [E-1:0]        absde_ff;
   logic [E:0]          nthr_ff;
   logic                fast_ff;

   // Scorer pipeline.
   logic [SW-1:0] s_ff [4];
   logic [1:0]    top_ff;
   logic [SW-1:0] d_ff;
   logic          ctap_ff, cswp_ff, cgrd_ff, clamp_ff;
   logic [22:0]   y_ff;
   logic [16:0]   q0_ff;

   // Decision counters.
   logic [7:0] upv_ff, dnv_ff, upv_in, dnv_in;
   logic [5:0] sup_ff, sup_in, gto_ff, gto_in;
   logic [4:0] grd_ff, grd_in, vcl_ff, vcl_in, mrel_ff, mrel_in;
   logic [6:0] lock_ff, lock_in;
   logic [1:0] total_ff, total_in, deb_ff, deb_in;
   logic [2:0] cc_ff, cc_in;
   logic       armed_ff, armed_in, wasact_ff, wasact_in, mlatch_ff, mlatch_in;

   logic                        rsp_valid_ff;
   logic [rtsgd_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Feature step signals.
   logic [E-1:0]      base_seed, prev_seed, base_new, absde_c, avga_new, noise_new;
   logic [E+4:0]      base_sum;
   logic signed [E:0] delta_c, de_c, avgd_new, avgc_new;
   logic signed [E+3:0] td, tc;
   logic [E+2:0]      ta;
   logic [E+3:0]      tn;
   logic [E:0]        dthr, nthr_c;
   logic [E+1:0]      fast_lim;

   // Score step signals.
   logic [SW-1:0] dl_x, de_x, ad_x, ac_x, absd_x, absde_x, absad_x, absac_x, aac_x;
   logic [SW-1:0] up_x, dn_x, hsum_x, f0, f1, fc;
   logic [SW-1:0] s_c [4];

   // Rank step signals.
   logic [1:0]    top_c, second_c;
   logic [SW-1:0] d_c;

   // Scale and quotient.
   logic [26:0] nine_d;
   logic [38:0] qmul;
   logic [23:0] rem_c;
   logic [15:0] conf_c;

   assign status.out_blocked = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mot_thr_ff   <= rtsgd_pkg::RST_MOTION_ON;
         votes_cfg_ff <= rtsgd_pkg::RST_VOTES;
         group_cfg_ff <= rtsgd_pkg::RST_GROUP;
         dop_ff       <= rtsgd_pkg::RST_DOPPLER;
         zone_ff      <= rtsgd_pkg::RST_ZONE;
         tds_ff       <= rtsgd_pkg::RST_TAP_DELTA;
         trs_ff       <= rtsgd_pkg::RST_TAP_RISE;
         tfs_ff       <= rtsgd_pkg::RST_TAP_FALL;
      end else if (csr_valid) begin
         unique case (csr_index)
            rtsgd_pkg::CSR_MOTION_ON:    mot_thr_ff   <= csr_data;
            rtsgd_pkg::CSR_SWIPE_VOTES:  votes_cfg_ff <= csr_data[7:0];
            rtsgd_pkg::CSR_GROUP_FRAMES: group_cfg_ff <= csr_data[5:0];
            rtsgd_pkg::CSR_DOPPLER:      dop_ff       <= csr_data;
            rtsgd_pkg::CSR_ZONE:         zone_ff      <= csr_data;
            rtsgd_pkg::CSR_TAP_DELTA:    tds_ff       <= csr_data;
            rtsgd_pkg::CSR_TAP_RISE:     trs_ff       <= csr_data;
            rtsgd_pkg::CSR_TAP_FALL:     tfs_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // The first frame seeds a zero baseline and a zero previous energy.
   always_comb begin
      base_seed = (base_ff == '0) ? e_ff : base_ff;
      prev_seed = (prev_ff == '0) ? e_ff : prev_ff;
      base_sum  = ({5'd0, base_seed} << 5) - {5'd0, base_seed} + {5'd0, e_ff};
      base_new  = base_sum[E+4:5];
      delta_c   = $signed({1'b0, e_ff}) - $signed({1'b0, base_new});
      de_c      = $signed({1'b0, e_ff}) - $signed({1'b0, prev_seed});
      absde_c   = de_c[E] ? E'(-de_c) : E'(de_c);
      td = ((E+4)'(avgd_ff) <<< 3) - (E+4)'(avgd_ff) + (E+4)'(delta_c);
      tc = ((E+4)'(avgc_ff) <<< 3) - (E+4)'(avgc_ff) + (E+4)'(de_c);
      avgd_new = td[E+3] ? (E+1)'((td + (E+4)'(7)) >>> 3) : (E+1)'(td >>> 3);
      avgc_new = tc[E+3] ? (E+1)'((tc + (E+4)'(7)) >>> 3) : (E+1)'(tc >>> 3);
      ta = ({3'd0, avga_ff} << 3) - {3'd0, avga_ff} + {3'd0, absde_c};
      avga_new = ta[E+2:3];
      tn = ({4'd0, noise_ff} << 4) - {4'd0, noise_ff} + {4'd0, absde_c};
      noise_new = tn[E+3:4];
      dthr = {1'b0, noise_new} + (E+1)'(rtsgd_pkg::DERIV_MARGIN);
      if (dthr < (E+1)'(rtsgd_pkg::DERIV_MIN)) begin
         dthr = (E+1)'(rtsgd_pkg::DERIV_MIN);
      end
      nthr_c = dthr >> 1;
      if (nthr_c < (E+1)'(4)) begin
         nthr_c = (E+1)'(4);
      end
      fast_lim = {1'b0, dthr} + (E+2)'(rtsgd_pkg::FAST_MARGIN);
   end

   // Scores are kept in units of 1/(100 * 2^15).
   always_comb begin
      dl_x    = SW'(delta_ff);
      de_x    = SW'(de_ff);
      ad_x    = SW'(avgd_ff);
      ac_x    = SW'(avgc_ff);
      absd_x  = delta_ff[E] ? -dl_x : dl_x;
      absad_x = avgd_ff[E] ? -ad_x : ad_x;
      absac_x = avgc_ff[E] ? -ac_x : ac_x;
      absde_x = SW'(absde_ff);
      aac_x   = SW'(avga_ff);
      up_x    = (cls_ff == rtsgd_pkg::HINT_UP) ? SW'(score_ff) : '0;
      dn_x    = (cls_ff == rtsgd_pkg::HINT_DOWN) ? SW'(score_ff) : '0;
      hsum_x  = up_x + dn_x;
      f0 = SW'(25) * absd_x + SW'(85) * absde_x + SW'(25) * absac_x;
      f1 = SW'(70) * dl_x + SW'(105) * de_x + SW'(110) * absde_x + SW'(45) * aac_x;
      fc = SW'(55) * absde_x + SW'(15) * absad_x;
      s_c[0] = (SW'(85) << 15) - (f0 << 9) - SW'(120) * hsum_x;
      s_c[1] = (f1 << 9) - (SW'(125) << 15) - SW'(80) * hsum_x;
      s_c[2] = SW'(235) * up_x - SW'(55) * dn_x - (fc << 9) - (SW'(95) << 15);
      s_c[3] = SW'(235) * dn_x - SW'(55) * up_x - (fc << 9) - (SW'(95) << 15);
   end

   always_comb begin
      top_c    = 2'd0;
      second_c = 2'd1;
      for (int i = 1; i < 4; i++) begin
         if ($signed(s_ff[i]) > $signed(s_ff[top_c])) begin
            second_c = top_c;
            top_c    = 2'(i);
         end else if (2'(i) != top_c && $signed(s_ff[i]) > $signed(s_ff[second_c])) begin
            second_c = 2'(i);
         end
      end
      d_c = s_ff[top_c] - s_ff[second_c];
   end

   assign nine_d = ({4'd0, d_ff[22:0]} << 3) + {4'd0, d_ff[22:0]};
   assign qmul   = {16'd0, y_ff} * 39'(rtsgd_pkg::RECIP_125);
   assign rem_c  = {1'b0, y_ff} - ({7'd0, q0_ff} * 24'd125);
   assign conf_c = clamp_ff ? 16'h8000 :
                   ((rem_c >= 24'd125) ? 16'(q0_ff + 17'd1) : q0_ff[15:0]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff     <= req_tdata[E-1:0];
         cls_ff   <= req_tdata[E+2:E];
         score_ff <= req_tdata[E+18:E+3];
      end
      if (cmd.feat) begin
         delta_ff <= delta_c;
         de_ff    <= de_c;
         absde_ff <= absde_c;
         nthr_ff  <= nthr_c;
         fast_ff  <= {2'b00, absde_c} >= fast_lim;
      end
      if (cmd.score) begin
         for (int k = 0; k < 4; k++) begin
            s_ff[k] <= s_c[k];
         end
      end
      if (cmd.rank) begin
         top_ff  <= top_c;
         d_ff    <= d_c;
         ctap_ff <= $signed(d_c) >= $signed(SW'(rtsgd_pkg::CONF_TAP_MIN));
         cswp_ff <= $signed(d_c) >= $signed(SW'(rtsgd_pkg::CONF_SWIPE_MIN));
         cgrd_ff <= $signed(d_c) >= $signed(SW'(rtsgd_pkg::CONF_GUARD_MIN));
      end
      if (cmd.scale) begin
         clamp_ff <= $signed(d_ff) >= $signed(SW'(rtsgd_pkg::CONF_CLAMP_MIN));
         y_ff     <= nine_d[26:4];
      end
      if (cmd.quot) begin
         q0_ff <= qmul[38:22];
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         prev_ff  <= '0;
         noise_ff <= E'(1);
         avgd_ff  <= '0;
         avgc_ff  <= '0;
         avga_ff  <= '0;
      end else if (cmd.feat) begin
         base_ff  <= base_new;
         prev_ff  <= e_ff;
         noise_ff <= noise_new;
         avgd_ff  <= avgd_new;
         avgc_ff  <= avgc_new;
         avga_ff  <= avga_new;
      end
   end

   // Vote, guard, lockout, tap, swipe and motion logic for one frame.
   always_comb begin
      logic signed [CW-1:0] dl, zn;
      logic [CW-1:0] ab;
      logic [1:0] taps, swipe;
      logic quiet, in_zone, hint_up, hint_dn, active, pending, open_w;
      logic strong_arm, scored;
      logic [7:0] need;
      logic [5:0] group;

      dl      = CW'(delta_ff);
      zn      = $signed(CW'(zone_ff));
      ab      = CW'(absde_ff);
      need    = (votes_cfg_ff == 8'd0) ? 8'd1 : votes_cfg_ff;
      group   = (group_cfg_ff == 6'd0) ? 6'd1 : group_cfg_ff;
      taps    = 2'd0;
      swipe   = rtsgd_pkg::SWIPE_NONE;
      hint_up = 1'b0;
      hint_dn = 1'b0;

      deb_in  = (deb_ff != '0) ? deb_ff - 2'd1 : deb_ff;
      sup_in  = (sup_ff != '0) ? sup_ff - 6'd1 : sup_ff;
      grd_in  = (grd_ff != '0) ? grd_ff - 5'd1 : grd_ff;
      lock_in = (lock_ff != '0) ? lock_ff - 7'd1 : lock_ff;
      vcl_in  = (vcl_ff != '0) ? vcl_ff - 5'd1 : vcl_ff;
      gto_in   = gto_ff;
      total_in = total_ff;
      armed_in = armed_ff;
      cc_in    = cc_ff;
      upv_in   = upv_ff;
      dnv_in   = dnv_ff;
      if (gto_ff != '0) begin
         gto_in = gto_ff - 6'd1;
         if (gto_in == '0 && total_ff != '0) begin
            taps     = total_ff;
            total_in = 2'd0;
         end
      end

      in_zone = (dl >= -zn) && (dl <= zn);
      quiet   = ab <= CW'(dop_ff);
      if (top_ff == rtsgd_pkg::CLASS_UP && cswp_ff) begin
         if (quiet && in_zone) begin
            hint_up = 1'b1;
            if (upv_ff != 8'hFF) begin
               upv_in = upv_ff + 8'd1;
            end
         end
      end else if (upv_ff != '0) begin
         upv_in = upv_ff - 8'd1;
      end
      if (top_ff == rtsgd_pkg::CLASS_DOWN && cswp_ff) begin
         if (quiet && in_zone) begin
            hint_dn = 1'b1;
            if (dnv_ff != 8'hFF) begin
               dnv_in = dnv_ff + 8'd1;
            end
         end
      end else if (dnv_ff != '0) begin
         dnv_in = dnv_ff - 8'd1;
      end

      if ((top_ff == rtsgd_pkg::CLASS_UP || top_ff == rtsgd_pkg::CLASS_DOWN) && cgrd_ff &&
          ab <= CW'(dop_ff) + CW'(8)) begin
         grd_in   = rtsgd_pkg::GUARD_FRAMES;
         lock_in  = rtsgd_pkg::LOCKOUT_FRAMES;
         armed_in = 1'b0;
         cc_in    = 3'd0;
      end

      active = (upv_in != '0) || (dnv_in != '0);
      if (active != wasact_ff) begin
         vcl_in   = rtsgd_pkg::TRANSITION_FRAMES;
         armed_in = 1'b0;
         cc_in    = 3'd0;
      end
      wasact_in = active;

      if (cc_in != '0) begin
         cc_in = cc_in - 3'd1;
         if (cc_in == '0) begin
            armed_in = 1'b0;
         end
      end

      pending = active || hint_up || hint_dn || (grd_in != '0);
      open_w  = (sup_in == '0) && (lock_in == '0) && (vcl_in == '0) && !pending;
      strong_arm = (dl >= $signed(CW'(tds_ff))) && !de_ff[E] && fast_ff &&
                   (ab >= CW'(trs_ff));
      scored  = (top_ff == rtsgd_pkg::CLASS_TAP) && ctap_ff &&
                (dl >= $signed(CW'(tds_ff >> 1))) && !de_ff[E] && fast_ff &&
                (ab >= CW'(trs_ff >> 1));

      if (open_w && !armed_in && deb_in == '0 && (scored || strong_arm)) begin
         armed_in = 1'b1;
         cc_in    = rtsgd_pkg::CONFIRM_TIMEOUT;
      end
      if (open_w && armed_in && de_ff[E] && ab >= CW'(nthr_ff) && ab >= CW'(tfs_ff) &&
          fast_ff) begin
         if (total_in != 2'd3) begin
            total_in = total_in + 2'd1;
         end
         gto_in   = group;
         deb_in   = rtsgd_pkg::DEBOUNCE_FRAMES;
         armed_in = 1'b0;
         cc_in    = 3'd0;
      end

      if (dnv_in >= need) begin
         swipe = rtsgd_pkg::SWIPE_UP_SHOWN;
      end else if (upv_in >= need) begin
         swipe = rtsgd_pkg::SWIPE_DOWN_SHOWN;
      end
      if (swipe != rtsgd_pkg::SWIPE_NONE) begin
         upv_in   = 8'd0;
         dnv_in   = 8'd0;
         sup_in   = rtsgd_pkg::SUPPRESS_FRAMES;
         grd_in   = rtsgd_pkg::GUARD_FRAMES;
         lock_in  = rtsgd_pkg::LOCKOUT_FRAMES;
         armed_in = 1'b0;
         cc_in    = 3'd0;
         total_in = 2'd0;
         gto_in   = 6'd0;
      end

      mlatch_in = mlatch_ff;
      mrel_in   = mrel_ff;
      if (dl >= $signed(CW'(mot_thr_ff))) begin
         mlatch_in = 1'b1;
         mrel_in   = 5'd0;
      end else if (mlatch_ff) begin
         mrel_in = mrel_ff + 5'd1;
         if (mrel_in >= rtsgd_pkg::MOTION_RELEASE) begin
            mlatch_in = 1'b0;
            mrel_in   = 5'd0;
         end
      end

      rsp_data_in = {1'b0, conf_c, top_ff, mlatch_in, swipe, taps};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upv_ff    <= '0;
         dnv_ff    <= '0;
         sup_ff    <= '0;
         grd_ff    <= '0;
         lock_ff   <= '0;
         vcl_ff    <= '0;
         gto_ff    <= '0;
         total_ff  <= '0;
         deb_ff    <= '0;
         cc_ff     <= '0;
         armed_ff  <= 1'b0;
         wasact_ff <= 1'b0;
         mlatch_ff <= 1'b0;
         mrel_ff   <= '0;
      end else if (cmd.commit) begin
         upv_ff    <= upv_in;
         dnv_ff    <= dnv_in;
         sup_ff    <= sup_in;
         grd_ff    <= grd_in;
         lock_ff   <= lock_in;
         vcl_ff    <= vcl_in;
         gto_ff    <= gto_in;
         total_ff  <= total_in;
         deb_ff    <= deb_in;
         cc_ff     <= cc_in;
         armed_ff  <= armed_in;
         wasact_ff <= wasact_in;
         mlatch_ff <= mlatch_in;
         mrel_ff   <= mrel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

### design/radar_tap_swipe_gesture_detector.sv
// Takes one radar frame per request (mean energy, network class and score) and returns one
// result per frame: taps of a finished group, a swipe event, the motion latch, and the
// linear scorer's class with its Q1.15 confidence. A frame is taken when the block is idle
// and its result is loaded into the output register after the feature, score, ranking,
// scaling, quotient and decision steps, run in that fixed order through one shared
// datapath; no new frame is taken until that result is loaded. The next request is taken
// while a result still waits in the output register; only the final decision step waits
// for that register to drain. Configuration is always ready.
module radar_tap_swipe_gesture_detector #(
   parameter int ENERGY_BITS = rtsgd_pkg::ENERGY_BITS_DEF,
   localparam int REQ_BITS = ((ENERGY_BITS + 19 + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // frame_energy, model_class, network score, zero fill.
   input  logic [REQ_BITS-1:0]                  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tap_group_taps, swipe_event, motion_active, scored_class, scored_confidence, zero fill.
   output logic [rtsgd_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rtsgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rtsgd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   rtsgd_pkg::dp_cmd_type    cmd;
   rtsgd_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   rtsgd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rtsgd_dp #(
      .ENERGY_BITS (ENERGY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### design/rtsgd_check.sv
`include "radar_tap_swipe_gesture_detector_defines.svh"

module rtsgd_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rtsgd_pkg::RSP_BITS-1:0] rsp_tdata
);

   `RTSGD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `RTSGD_ASSERT_IMP(a_swipe_code, clock, reset, rsp_tvalid, rsp_tdata[3:2] != 2'b11)
   `RTSGD_ASSERT_IMP(a_conf_clamp, clock, reset, rsp_tvalid && rsp_tdata[22], rsp_tdata[21:7] == 15'd0)
   `RTSGD_ASSERT_NXT(a_one_frame, clock, reset, req_tvalid && req_tready, !req_tready)
   `RTSGD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind radar_tap_swipe_gesture_detector rtsgd_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int EB = rtsgd_pkg::ENERGY_BITS_DEF;
   localparam int REQ_W = ((EB + 19 + 7) / 8) * 8;
   localparam longint C_ONE = 2097152;
   localparam longint F_ONE = 32768;
   localparam longint H_ONE = 64;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [1:0]  taps;
      logic [1:0]  swipe;
      logic        motion;
      logic [1:0]  cls;
      logic [15:0] conf;
   } gesture_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [rtsgd_pkg::RSP_BITS-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [rtsgd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rtsgd_pkg::CSR_DATA_BITS-1:0] csr_data;

   radar_tap_swipe_gesture_detector dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Configuration and state of the gesture predictor.
   int cfg_motion_on, cfg_votes, cfg_group, cfg_doppler, cfg_zone;
   int cfg_tap_delta, cfg_tap_rise, cfg_tap_fall;
   int baseline, prev_e, dnoise, avg_dlt, avg_chg, avg_abs;
   int up_v, dn_v, suppress_c, guard_c, lockout_c, vchange_c, group_c;
   int tap_cnt, debounce_c, confirm_c, rel_c;
   bit armed, votes_active, motion;

   gesture_result_type expected_results[$];
   int errors = 0;
   int frames_sent;
   int groups_seen = 0;
   int swipes_seen = 0;
   int motion_seen = 0;
   int idle_cycles;
   bit sender_gaps;
   bit receiver_stalls;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int dec1(int v);
      return (v > 0) ? v - 1 : 0;
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic reset_gesture_state();
      cfg_motion_on = rtsgd_pkg::RST_MOTION_ON; cfg_votes = rtsgd_pkg::RST_VOTES;
      cfg_group = rtsgd_pkg::RST_GROUP; cfg_doppler = rtsgd_pkg::RST_DOPPLER;
      cfg_zone = rtsgd_pkg::RST_ZONE; cfg_tap_delta = rtsgd_pkg::RST_TAP_DELTA;
      cfg_tap_rise = rtsgd_pkg::RST_TAP_RISE; cfg_tap_fall = rtsgd_pkg::RST_TAP_FALL;
      baseline = 0; prev_e = 0; dnoise = 1; avg_dlt = 0; avg_chg = 0; avg_abs = 0;
      up_v = 0; dn_v = 0; suppress_c = 0; guard_c = 0; lockout_c = 0; vchange_c = 0;
      group_c = 0; tap_cnt = 0; debounce_c = 0; confirm_c = 0;
      armed = 0; votes_active = 0; motion = 0; rel_c = 0;
   endtask

   task automatic predict_gesture(input int e, input int hint, input int score,
                                  output gesture_result_type r);
      int votes_need, grp, delta, de, abs_de, top, second, dthr, nthr;
      longint up_h, dn_h, hsum, common, prod, conf;
      longint sc[4];
      bit conf_tap, conf_swipe, conf_guard, fast, in_zone, quiet, hint_up, hint_dn;
      bit act, pending, open_win, strong_arm, scored;
      r.taps = 2'd0;
      r.swipe = rtsgd_pkg::SWIPE_NONE;
      votes_need = (cfg_votes != 0) ? cfg_votes : 1;
      grp = (cfg_group != 0) ? cfg_group : 1;
      if (prev_e == 0) prev_e = e;
      if (baseline == 0) baseline = e;
      baseline = (baseline * 31 + e) / 32;
      delta = e - baseline;
      de = e - prev_e;
      abs_de = (de < 0) ? -de : de;
      up_h = (hint == rtsgd_pkg::HINT_UP) ? score : 0;
      dn_h = (hint == rtsgd_pkg::HINT_DOWN) ? score : 0;
      hsum = up_h + dn_h;
      avg_dlt = (avg_dlt * 7 + delta) / 8;
      avg_chg = (avg_chg * 7 + de) / 8;
      avg_abs = (avg_abs * 7 + abs_de) / 8;
      common = -(55 * longint'(abs_de) + 15 * mag(avg_dlt)) * F_ONE;
      sc[0] = 85 * C_ONE - (25 * mag(delta) + 85 * longint'(abs_de) + 25 * mag(avg_chg)) * F_ONE
              - 120 * hsum * H_ONE;
      sc[1] = -125 * C_ONE + (70 * longint'(delta) + 105 * longint'(de)
              + 110 * longint'(abs_de) + 45 * longint'(avg_abs)) * F_ONE - 80 * hsum * H_ONE;
      sc[2] = -95 * C_ONE + common + (235 * up_h - 55 * dn_h) * H_ONE;
      sc[3] = -95 * C_ONE + common + (235 * dn_h - 55 * up_h) * H_ONE;
      top = 0;
      second = 1;
      for (int i = 1; i < 4; i++) begin
         if (sc[i] > sc[top]) begin
            second = top;
            top = i;
         end else if (i != top && sc[i] > sc[second]) begin
            second = i;
         end
      end
      prod = 45 * (sc[top] - sc[second]);
      conf = prod / 640000;
      if (conf < 0) conf = 0;
      if (conf > 32768) conf = 32768;
      conf_tap = prod >= 2500 * C_ONE;
      conf_swipe = prod >= 1800 * C_ONE;
      conf_guard = prod >= 1400 * C_ONE;
      dnoise = (dnoise * 15 + abs_de) / 16;
      dthr = dnoise + rtsgd_pkg::DERIV_MARGIN;
      if (dthr < rtsgd_pkg::DERIV_MIN) dthr = rtsgd_pkg::DERIV_MIN;
      nthr = dthr / 2;
      if (nthr < 4) nthr = 4;
      fast = abs_de >= dthr + rtsgd_pkg::FAST_MARGIN;
      prev_e = e;
      debounce_c = dec1(debounce_c); suppress_c = dec1(suppress_c); guard_c = dec1(guard_c);
      lockout_c = dec1(lockout_c); vchange_c = dec1(vchange_c);
      if (group_c > 0) begin
         group_c--;
         if (group_c == 0 && tap_cnt > 0) begin
            r.taps = 2'(tap_cnt);
            tap_cnt = 0;
         end
      end
      in_zone = delta >= -cfg_zone && delta <= cfg_zone;
      quiet = abs_de <= cfg_doppler;
      hint_up = 0;
      hint_dn = 0;
      if (top == rtsgd_pkg::CLASS_UP && conf_swipe) begin
         if (quiet && in_zone) begin
            hint_up = 1;
            if (up_v < 255) up_v++;
         end
      end else begin
         up_v = dec1(up_v);
      end
      if (top == rtsgd_pkg::CLASS_DOWN && conf_swipe) begin
         if (quiet && in_zone) begin
            hint_dn = 1;
            if (dn_v < 255) dn_v++;
         end
      end else begin
         dn_v = dec1(dn_v);
      end
      if ((top == rtsgd_pkg::CLASS_UP || top == rtsgd_pkg::CLASS_DOWN) && conf_guard &&
          abs_de <= cfg_doppler + 8) begin
         guard_c = rtsgd_pkg::GUARD_FRAMES;
         lockout_c = rtsgd_pkg::LOCKOUT_FRAMES;
         armed = 0;
         confirm_c = 0;
      end
      act = up_v > 0 || dn_v > 0;
      if (act != votes_active) begin
         vchange_c = rtsgd_pkg::TRANSITION_FRAMES;
         armed = 0;
         confirm_c = 0;
      end
      votes_active = act;
      if (confirm_c > 0) begin
         confirm_c--;
         if (confirm_c == 0) armed = 0;
      end
      pending = act || hint_up || hint_dn || guard_c > 0;
      open_win = suppress_c == 0 && lockout_c == 0 && vchange_c == 0 && !pending;
      strong_arm = delta >= cfg_tap_delta && de >= 0 && fast && abs_de >= cfg_tap_rise;
      scored = top == rtsgd_pkg::CLASS_TAP && conf_tap && delta >= cfg_tap_delta / 2 &&
               de >= 0 && fast && abs_de >= cfg_tap_rise / 2;
      if (open_win && !armed && debounce_c == 0 && (scored || strong_arm)) begin
         armed = 1;
         confirm_c = rtsgd_pkg::CONFIRM_TIMEOUT;
      end
      if (open_win && armed && de < 0 && abs_de >= nthr && abs_de >= cfg_tap_fall &&
          fast) begin
         if (tap_cnt < 3) tap_cnt++;
         group_c = grp;
         debounce_c = rtsgd_pkg::DEBOUNCE_FRAMES;
         armed = 0;
         confirm_c = 0;
      end
      if (dn_v >= votes_need) r.swipe = rtsgd_pkg::SWIPE_UP_SHOWN;
      else if (up_v >= votes_need) r.swipe = rtsgd_pkg::SWIPE_DOWN_SHOWN;
      if (r.swipe != rtsgd_pkg::SWIPE_NONE) begin
         up_v = 0; dn_v = 0;
         suppress_c = rtsgd_pkg::SUPPRESS_FRAMES;
         guard_c = rtsgd_pkg::GUARD_FRAMES;
         lockout_c = rtsgd_pkg::LOCKOUT_FRAMES;
         armed = 0; confirm_c = 0;
         tap_cnt = 0; group_c = 0;
      end
      if (delta >= cfg_motion_on) begin
         motion = 1;
         rel_c = 0;
      end else if (motion) begin
         rel_c++;
         if (rel_c >= rtsgd_pkg::MOTION_RELEASE) begin
            motion = 0;
            rel_c = 0;
         end
      end
      r.motion = motion;
      r.cls = 2'(top);
      r.conf = 16'(conf);
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!sender_gaps || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_frame(input int e, input int hint, input int score);
      gesture_result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({score[15:0], hint[2:0], e[EB-1:0]});
      do @(posedge clock); while (!req_tready);
      predict_gesture(e, hint, score, r);
      expected_results.push_back(r);
      frames_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input rtsgd_pkg::csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[rtsgd_pkg::CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         rtsgd_pkg::CSR_MOTION_ON:    cfg_motion_on = value & 12'hFFF;
         rtsgd_pkg::CSR_SWIPE_VOTES:  cfg_votes = value & 8'hFF;
         rtsgd_pkg::CSR_GROUP_FRAMES: cfg_group = value & 6'h3F;
         rtsgd_pkg::CSR_DOPPLER:      cfg_doppler = value & 12'hFFF;
         rtsgd_pkg::CSR_ZONE:         cfg_zone = value & 12'hFFF;
         rtsgd_pkg::CSR_TAP_DELTA:    cfg_tap_delta = value & 12'hFFF;
         rtsgd_pkg::CSR_TAP_RISE:     cfg_tap_rise = value & 12'hFFF;
         rtsgd_pkg::CSR_TAP_FALL:     cfg_tap_fall = value & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic write_all_csrs(input int mo, input int vo, input int gr, input int dop,
                                 input int zo, input int td, input int tr, input int tf);
      drain_results();
      write_csr(rtsgd_pkg::CSR_MOTION_ON, mo);
      write_csr(rtsgd_pkg::CSR_SWIPE_VOTES, vo);
      write_csr(rtsgd_pkg::CSR_GROUP_FRAMES, gr);
      write_csr(rtsgd_pkg::CSR_DOPPLER, dop);
      write_csr(rtsgd_pkg::CSR_ZONE, zo);
      write_csr(rtsgd_pkg::CSR_TAP_DELTA, td);
      write_csr(rtsgd_pkg::CSR_TAP_RISE, tr);
      write_csr(rtsgd_pkg::CSR_TAP_FALL, tf);
      csr_valid <= 1'b0;
   endtask

   task automatic tap_sequence(input int level);
      int taps;
      repeat ($urandom_range(4, 12)) send_frame(level + $urandom_range(0, 3), $urandom_range(0, 5),
                                                $urandom_range(0, 32768));
      taps = $urandom_range(1, 4);
      repeat (taps) begin
         send_frame(level + $urandom_range(40, 400), $urandom_range(0, 5),
                    $urandom_range(0, 32768));
         if ($urandom_range(0, 3) == 0)
            send_frame(level + $urandom_range(40, 400), 1, $urandom_range(0, 32768));
         send_frame(level + $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 32768));
         repeat ($urandom_range(2, 6)) send_frame(level + $urandom_range(0, 3), 0, 0);
      end
      repeat ($urandom_range(0, 30)) send_frame(level + $urandom_range(0, 3), 0, 0);
   endtask

   task automatic swipe_sequence(input int level);
      int hint;
      hint = $urandom_range(0, 1) ? rtsgd_pkg::HINT_UP : rtsgd_pkg::HINT_DOWN;
      repeat ($urandom_range(2, 10))
         send_frame(level + $urandom_range(0, 6), hint, $urandom_range(16000, 32768));
      repeat ($urandom_range(0, 40)) send_frame(level + $urandom_range(0, 3), 0, 0);
   endtask

   task automatic noise_frame();
      int e;
      case ($urandom_range(0, 3))
         0: e = $urandom_range(0, (1 << EB) - 1);
         1: e = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         default: e = 2048 + $urandom_range(0, 64);
      endcase
      send_frame(e, $urandom_range(0, 7), $urandom_range(0, 65535));
   endtask

   task automatic run_mixed(input int n);
      int level, goal;
      goal = frames_sent + n;
      while (frames_sent < goal) begin
         level = $urandom_range(50, 3000);
         case ($urandom_range(0, 9)) inside
            [0:3]:   tap_sequence(level);
            [4:6]:   swipe_sequence(level);
            default: repeat ($urandom_range(1, 8)) noise_frame();
         endcase
      end
   endtask

   task automatic test_field_extremes();
      int hints[8] = '{0, 1, 2, 3, 4, 5, 6, 7};
      send_frame(0, 0, 0);
      send_frame((1 << EB) - 1, 7, 65535);
      send_frame(1, 6, 32768);
      send_frame((1 << EB) - 1, 0, 0);
      send_frame(0, 6, 65535);
      send_frame(1000, 7, 32768);
      foreach (hints[i]) send_frame(1000 + 40 * i, hints[i], 32768 - 1000 * i);
      send_frame(1000, 6, 32767);
      send_frame(1000, 7, 1);
      send_frame(2730, 5, 21845);
      send_frame(1365, 2, 43690);
      drain_results();
   endtask

   task automatic test_default_gestures();
      repeat (4) tap_sequence(600);
      repeat (4) swipe_sequence(900);
      drain_results();
   endtask

   task automatic test_config_extremes();
      write_all_csrs(0, 0, 0, 0, 0, 0, 0, 0);
      run_mixed(120);
      write_all_csrs(4095, 255, 63, 4095, 4095, 4095, 4095, 4095);
      run_mixed(120);
      write_all_csrs(2730, 170, 42, 2730, 1365, 2730, 1365, 2730);
      run_mixed(80);
      write_all_csrs(1365, 85, 21, 1365, 2730, 1365, 2730, 1365);
      run_mixed(80);
      write_all_csrs(20, 1, 1, 30, 30, 20, 30, 20);
      run_mixed(100);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         write_all_csrs($urandom_range(0, 60), $urandom_range(1, 4), $urandom_range(1, 30),
                        $urandom_range(8, 40), $urandom_range(8, 40), $urandom_range(10, 60),
                        $urandom_range(10, 80), $urandom_range(10, 60));
         sender_gaps = phase % 3 != 0;
         receiver_stalls = phase % 4 != 1;
         run_mixed(40);
      end
      sender_gaps = 1;
      receiver_stalls = 1;
   endtask

   task automatic test_sender_pause();
      repeat (3) tap_sequence(700);
      if (req_tvalid) req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (3) swipe_sequence(700);
      drain_results();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!receiver_stalls) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_tready <= $urandom_range(0, 99) < 70;
      end
   end

   always @(posedge clock) begin
      gesture_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.taps = rsp_tdata[1:0];
         got.swipe = rsp_tdata[3:2];
         got.motion = rsp_tdata[4];
         got.cls = rsp_tdata[6:5];
         got.conf = rsp_tdata[22:7];
         if (got.taps != 0) groups_seen++;
         if (got.swipe != rtsgd_pkg::SWIPE_NONE) swipes_seen++;
         if (got.motion) motion_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h with nothing pending", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got.taps !== want.taps || got.swipe !== want.swipe ||
                got.motion !== want.motion || got.cls !== want.cls ||
                got.conf !== want.conf) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch (exp/act): taps %0d/%0d swipe %0d/%0d ",
                            "motion %0d/%0d class %0d/%0d conf %0d/%0d"},
                           want.taps, got.taps, want.swipe, got.swipe, want.motion,
                           got.motion, want.cls, got.cls, want.conf, got.conf);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      frames_sent = 0;
      sender_gaps = 1;
      receiver_stalls = 1;
      reset_gesture_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_default_gestures();
      test_config_extremes();
      test_sender_pause();
      test_random_traffic();
      drain_results();
      $display("Sent %0d frames across several register settings.", frames_sent);
      $display("Results held %0d tap groups, %0d swipes and %0d frames with motion.",
               groups_seen, swipes_seen, motion_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+design
design/rtsgd_pkg.sv
design/rtsgd_ctrl.sv
design/rtsgd_dp.sv
design/radar_tap_swipe_gesture_detector.sv
design/rtsgd_check.sv
tb/tb_top.sv
